FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker module of the grid path checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define GPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define GPC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: hdl/gpc_pkg.sv
// ---------------------------------------------------------------------------
// gpc_pkg
// Widths, codes and helper functions of the grid path checker.
// ---------------------------------------------------------------------------
`default_nettype none

package gpc_pkg;

    // Default grid storage size.
    localparam int DEFAULT_MAX_ROWS = 64;
    localparam int DEFAULT_MAX_COLS = 64;

    // Field widths.
    localparam int KIND_W    = 2;
    localparam int COORD_W   = 8;
    localparam int WEIGHT_W  = 16;
    localparam int STATUS_W  = 2;
    localparam int SUM_W     = 32;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STEP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    // Verdict codes.
    localparam logic [STATUS_W-1:0] STATUS_SIMPLE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REPEAT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

    // Register reset values.
    localparam logic [CFG_W-1:0] RESET_NUM_ROWS = 7'd64;
    localparam logic [CFG_W-1:0] RESET_NUM_COLS = 7'd64;

    // Verdict of the current walk from its flags.
    function automatic logic [STATUS_W-1:0] verdict(input logic failed, input logic simple);
        logic [STATUS_W-1:0] code;
        if (failed) begin
            code = STATUS_INVALID;
        end else if (simple) begin
            code = STATUS_SIMPLE;
        end else begin
            code = STATUS_REPEAT;
        end
        return code;
    endfunction

    // Adds a cell weight to the running sum, clamping at the signed limits.
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                 input logic [WEIGHT_W-1:0] w);
        logic [SUM_W:0]   wide;
        logic [SUM_W-1:0] res;
        wide = {acc[SUM_W-1], acc} + {{(SUM_W-WEIGHT_W+1){w[WEIGHT_W-1]}}, w};
        if (wide[SUM_W] != wide[SUM_W-1]) begin
            res = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            res = wide[SUM_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/grid_path_checker_top.sv
// ---------------------------------------------------------------------------
// grid_path_checker_top
// Checks a king-move walk over a grid of signed cell weights, one request
// per coordinate, and reports the verdict and the saturating weight sum.
// ---------------------------------------------------------------------------
// A result is loaded into the output register from the evaluate state that
// follows acceptance (memory words are read at acceptance, then evaluated).
// Requests are taken one at a time; evaluation waits for a free output register.
// An end-of-path request is followed by a clearing pass over every cell of the
// visited map, during which s_ready is low.
// Reset: synchronous, active low; the same clearing pass runs after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module grid_path_checker_top #(
    parameter int MAX_ROWS = gpc_pkg::DEFAULT_MAX_ROWS,
    parameter int MAX_COLS = gpc_pkg::DEFAULT_MAX_COLS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Request channel.
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic        [gpc_pkg::KIND_W-1:0]    s_kind,
    input  logic signed [gpc_pkg::COORD_W-1:0]   s_row,
    input  logic signed [gpc_pkg::COORD_W-1:0]   s_col,
    input  logic signed [gpc_pkg::WEIGHT_W-1:0]  s_cell_weight,
    // Result channel.
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic        [gpc_pkg::STATUS_W-1:0]  m_status,
    output logic signed [gpc_pkg::SUM_W-1:0]     m_weight_sum,
    output logic                                 m_is_final,
    // Configuration write port.
    input  logic                                 cfg_we,
    input  logic        [gpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [gpc_pkg::CFG_W-1:0]     cfg_wdata
);

    import gpc_pkg::*;

    // Storage geometry. Cell (r, c) lives at address r * MAX_COLS + c.
    localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    // Coordinates are compared two bits wider so the limits always fit.
    localparam int CMP_W      = COORD_W + 2;

    // The sequencer has three states: waiting for a request, evaluating the
    // request whose memory words were read at acceptance, and sweeping the
    // visited map back to zero.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_CLEAR = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Request held during evaluation.
    logic [KIND_W-1:0]   kind_reg;
    logic [COORD_W-1:0]  row_reg;
    logic [COORD_W-1:0]  col_reg;
    logic [WEIGHT_W-1:0] wgt_reg;
    logic [ADDR_W-1:0]   addr_reg;

    // Memories and their registered read data.
    logic [WEIGHT_W-1:0] grid_mem [CELL_COUNT];
    logic                vis_mem  [CELL_COUNT];
    logic [WEIGHT_W-1:0] grid_rd_reg;
    logic                vis_rd_reg;

    // Configuration registers.
    logic [CFG_W-1:0] num_rows_reg;
    logic [CFG_W-1:0] num_cols_reg;

    // Walk state.
    logic [COORD_W-1:0] last_row_reg, last_row_next;
    logic [COORD_W-1:0] last_col_reg, last_col_next;
    logic               started_reg, started_next;
    logic               simple_reg, simple_next;
    logic               failed_reg, failed_next;
    logic [SUM_W-1:0]   run_wgt_reg, run_wgt_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [SUM_W-1:0]    m_sum_reg;
    logic                m_final_reg;

    // Clearing sweep address.
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic              accept;
    logic              out_free;
    logic              fire;
    logic [ADDR_W-1:0] s_addr;

    logic               row_ok, col_ok, row_store, col_store;
    logic [COORD_W:0]   drow, dcol;
    logic               near;
    logic               step_pass;
    logic               is_step, is_load, is_end;
    logic               failed_post, simple_post;
    logic [SUM_W-1:0]   run_wgt_post;
    logic [SUM_W-1:0]   sum_sat;

    logic              grid_we;
    logic              vis_we;
    logic [ADDR_W-1:0] vis_waddr;
    logic              vis_wdata;

    // -----------------------------------------------------------------------
    // Handshakes
    // -----------------------------------------------------------------------
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    // The output register can take a new result when it is empty or its
    // current result is being taken in this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = (state_reg == ST_EXEC) && out_free;

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_weight_sum = m_sum_reg;
    assign m_is_final   = m_final_reg;

    // Memory address of the requested cell. Out-of-storage coordinates give
    // a meaningless address, but such a request never uses the data read.
    assign s_addr = ADDR_W'(ADDR_W'(s_row[ROW_W-1:0]) * ADDR_W'(MAX_COLS))
                  + ADDR_W'(s_col[COL_W-1:0]);

    // -----------------------------------------------------------------------
    // Evaluation of the held request
    // -----------------------------------------------------------------------
    assign is_load = (kind_reg == KIND_LOAD);
    assign is_step = (kind_reg == KIND_STEP);
    assign is_end  = (kind_reg == KIND_END);

    // A coordinate must be non-negative, below the configured size and below
    // the storage size; this also handles a configured size above storage.
    assign row_store = !row_reg[COORD_W-1]
                    && (CMP_W'(row_reg) < CMP_W'(MAX_ROWS));
    assign col_store = !col_reg[COORD_W-1]
                    && (CMP_W'(col_reg) < CMP_W'(MAX_COLS));
    assign row_ok    = row_store && (CMP_W'(row_reg) < CMP_W'(num_rows_reg));
    assign col_ok    = col_store && (CMP_W'(col_reg) < CMP_W'(num_cols_reg));

    // King-move neighbour test: both signed differences lie in -1..1.
    assign drow = {row_reg[COORD_W-1], row_reg} - {last_row_reg[COORD_W-1], last_row_reg};
    assign dcol = {col_reg[COORD_W-1], col_reg} - {last_col_reg[COORD_W-1], last_col_reg};
    assign near = ((drow == '0) || (drow == (COORD_W+1)'(1)) || (drow == '1))
               && ((dcol == '0) || (dcol == (COORD_W+1)'(1)) || (dcol == '1));

    assign step_pass = row_ok && col_ok && (!started_reg || near) && (grid_rd_reg != '0);

    // The saturating adder adds the stored weight of the stepped cell.
    assign sum_sat = sat_add(run_wgt_reg, grid_rd_reg);

    // Walk flags after the held request, before an end request resets them.
    always_comb begin
        failed_post  = failed_reg;
        simple_post  = simple_reg;
        run_wgt_post = run_wgt_reg;
        if (is_step && !failed_reg) begin
            if (step_pass) begin
                run_wgt_post = sum_sat;
                if (vis_rd_reg) begin
                    simple_post = 1'b0;
                end
            end else begin
                failed_post = 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sequencer
    // -----------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        last_row_next = last_row_reg;
        last_col_next = last_col_reg;
        started_next  = started_reg;
        simple_next   = simple_reg;
        failed_next   = failed_reg;
        run_wgt_next  = run_wgt_reg;
        clr_cnt_next  = clr_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (is_end) begin
                        // The verdict has been reported; start a new walk.
                        last_row_next = '0;
                        last_col_next = '0;
                        started_next  = 1'b0;
                        simple_next   = 1'b1;
                        failed_next   = 1'b0;
                        run_wgt_next  = '0;
                        clr_cnt_next  = '0;
                        state_next    = ST_CLEAR;
                    end else begin
                        failed_next  = failed_post;
                        simple_next  = simple_post;
                        run_wgt_next = run_wgt_post;
                        if (is_step && !failed_reg && step_pass) begin
                            last_row_next = row_reg;
                            last_col_next = col_reg;
                            started_next  = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(CELL_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            last_row_reg <= '0;
            last_col_reg <= '0;
            started_reg  <= 1'b0;
            simple_reg   <= 1'b1;
            failed_reg   <= 1'b0;
            run_wgt_reg  <= '0;
            clr_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            last_row_reg <= last_row_next;
            last_col_reg <= last_col_next;
            started_reg  <= started_next;
            simple_reg   <= simple_next;
            failed_reg   <= failed_next;
            run_wgt_reg  <= run_wgt_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_kind;
            row_reg  <= s_row;
            col_reg  <= s_col;
            wgt_reg  <= s_cell_weight;
            addr_reg <= s_addr;
        end
        if (fire) begin
            m_status_reg <= verdict(failed_post, simple_post);
            m_sum_reg    <= run_wgt_post;
            m_final_reg  <= is_end;
        end
    end

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= RESET_NUM_ROWS;
            num_cols_reg <= RESET_NUM_COLS;
        end else if (cfg_we) begin
            priority if (cfg_index == REG_NUM_ROWS) begin
                num_rows_reg <= cfg_wdata;
            end else if (cfg_index == REG_NUM_COLS) begin
                num_cols_reg <= cfg_wdata;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Memories
    // -----------------------------------------------------------------------
    // Loads inside the storage are kept even when outside the configured size.
    assign grid_we = fire && is_load && row_store && col_store;

    // A passing step marks its cell; the clearing sweep writes zeros.
    assign vis_we    = (state_reg == ST_CLEAR)
                    || (fire && is_step && !failed_reg && step_pass);
    assign vis_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr_reg;
    assign vis_wdata = (state_reg != ST_CLEAR);

    always_ff @(posedge aclk) begin
        if (grid_we) begin
            grid_mem[addr_reg] <= wgt_reg;
        end
        if (accept) begin
            grid_rd_reg <= grid_mem[s_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (vis_we) begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        if (accept) begin
            vis_rd_reg <= vis_mem[s_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/gpc_checker.sv
// ---------------------------------------------------------------------------
// gpc_checker
// Port-level checks of the grid path checker, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gpc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic        [gpc_pkg::STATUS_W-1:0] m_status,
    input logic signed [gpc_pkg::SUM_W-1:0]    m_weight_sum,
    input logic                                m_is_final
);

    // A stalled result keeps its values.
    `GPC_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_weight_sum) && $stable(m_is_final), "stalled result changed")

    // The block works on one request at a time.
    `GPC_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "request accepted while busy")

    // Reset starts the clearing sweep, so no request is taken right after it.
    `GPC_ASSERT_ALWAYS(a_clear_after_reset, aclk, !aresetn |=> !s_ready, "ready right after reset")

    // A new end-of-path result starts the clearing sweep.
    `GPC_ASSERT(a_clear_after_end, aclk, aresetn, $rose(m_valid) && m_is_final |-> !s_ready, "ready during clearing sweep")

endmodule

bind grid_path_checker_top gpc_checker u_gpc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_weight_sum (m_weight_sum),
    .m_is_final   (m_is_final)
);

`default_nettype wire
